### design/local_maximum_counter_core_assert.svh
// assertion macros shared by the local maximum counter modules
`ifndef LOCAL_MAXIMUM_COUNTER_CORE_ASSERT_SVH
`define LOCAL_MAXIMUM_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LMC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LMC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### design/lmc_pkg.sv
`timescale 1ns / 1ps
package lmc_pkg;
  localparam int COUNT_W = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int CFG_W = 11;
  // wide enough for any dimension up to 8192 plus one
  localparam int DIM_W = 14;
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
  localparam int INC_W = 3;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW = 2;

  typedef enum logic {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [INC_W-1:0] inc;
    logic             last;
  } peak_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;
endpackage

### design/lmc_front.sv
`timescale 1ns / 1ps
`include "local_maximum_counter_core_assert.svh"
module lmc_front #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  input  logic [lmc_pkg::CFG_W-1:0]       frame_rows,
  input  logic [lmc_pkg::CFG_W-1:0]       frame_cols,
  input  lmc_pkg::fifo_stat_t             fifo_stat,
  output logic                            push,
  output lmc_pkg::peak_rec_t              push_rec
);
  import lmc_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SB = SAMPLE_BITS;

  typedef logic signed [SB-1:0] win_t [3][3];
  typedef struct packed {
    logic r1;
    logic r2;
    logic c1;
    logic c2;
    logic lc;
    logic lr;
  } pos_flags_t;

  function automatic logic cell_peak(input win_t w, input int wr, input int wc,
                                     input logic up_ok, input logic left_ok);
    logic pk;
    int   nr;
    int   nc;
    pk = 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = wr + dr;
        nc = wc + dc;
        if (!(dr == 0 && dc == 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2 &&
            (dr != -1 || up_ok) && (dc != -1 || left_ok)) begin
          if (w[nr][nc] >= w[wr][wc]) begin
            pk = 1'b0;
          end
        end
      end
    end
    return pk;
  endfunction

  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [RW-1:0]    r_pos_r;
  logic [CW-1:0]    c_pos_r;
  pos_flags_t       a_flags;
  logic             en;
  logic             accept;

  // line stores packed as {two rows up, one row up}
  logic [2*SB-1:0]  mem [MAX_COLS];
  logic [2*SB-1:0]  rd_r;
  logic             fwd_r;
  logic [2*SB-1:0]  fwd_data_r;
  logic [2*SB-1:0]  b_pair;
  logic [2*SB-1:0]  b_wdata;

  logic             b_valid_r;
  logic signed [SB-1:0] b_sample_r;
  logic [CW-1:0]    b_idx_r;
  pos_flags_t       b_flags_r;

  logic             c_valid_r;
  pos_flags_t       c_flags_r;
  win_t             win_r;
  logic [3:0]       pk;

  always_comb begin
    priority if (frame_rows == '0) begin
      rows_eff = DIM_W'(1);
    end else if (DIM_W'(frame_rows) > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = DIM_W'(frame_rows);
    end
    priority if (frame_cols == '0) begin
      cols_eff = DIM_W'(1);
    end else if (DIM_W'(frame_cols) > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = DIM_W'(frame_cols);
    end
  end

  always_comb begin
    a_flags.r1 = (r_pos_r != '0);
    a_flags.r2 = (r_pos_r > RW'(1));
    a_flags.c1 = (c_pos_r != '0);
    a_flags.c2 = (c_pos_r > CW'(1));
    a_flags.lc = ((DIM_W'(c_pos_r) + DIM_W'(1)) >= cols_eff);
    a_flags.lr = ((DIM_W'(r_pos_r) + DIM_W'(1)) >= rows_eff);
  end

  // whole front advances together; it only stops when the queue is full
  assign en       = !(c_valid_r && fifo_stat.full);
  assign in_ready = en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_pos_r <= '0;
      c_pos_r <= '0;
    end else if (accept) begin
      if (!a_flags.lc) begin
        c_pos_r <= c_pos_r + CW'(1);
      end else begin
        c_pos_r <= '0;
        if (!a_flags.lr) begin
          r_pos_r <= r_pos_r + RW'(1);
        end else begin
          r_pos_r <= '0;
        end
      end
    end
  end

  assign b_pair  = fwd_r ? fwd_data_r : rd_r;
  assign b_wdata = {b_pair[SB-1:0], b_sample_r};

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= mem[c_pos_r];
      if (b_valid_r) begin
        mem[b_idx_r] <= b_wdata;
      end
    end
  end

  // same column written by the item ahead: take its write data instead
  always_ff @(posedge clk) begin
    if (en) begin
      fwd_r      <= b_valid_r && (b_idx_r == c_pos_r);
      fwd_data_r <= b_wdata;
      b_sample_r <= in_sample;
      b_idx_r    <= c_pos_r;
      b_flags_r  <= a_flags;
      c_flags_r  <= b_flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= in_valid;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (en && b_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= b_pair[2*SB-1:SB];
      win_r[1][2] <= b_pair[SB-1:0];
      win_r[2][2] <= b_sample_r;
    end
  end

  always_comb begin
    pk[0] = c_flags_r.r1 && c_flags_r.c1 &&
            cell_peak(win_r, 1, 1, c_flags_r.r2, c_flags_r.c2);
    pk[1] = c_flags_r.r1 && c_flags_r.lc &&
            cell_peak(win_r, 1, 2, c_flags_r.r2, c_flags_r.c1);
    pk[2] = c_flags_r.lr && c_flags_r.c1 &&
            cell_peak(win_r, 2, 1, c_flags_r.r1, c_flags_r.c2);
    pk[3] = c_flags_r.lr && c_flags_r.lc &&
            cell_peak(win_r, 2, 2, c_flags_r.r1, c_flags_r.c1);
  end

  assign push          = c_valid_r && !fifo_stat.full;
  assign push_rec.inc  = INC_W'(pk[0]) + INC_W'(pk[1]) + INC_W'(pk[2]) + INC_W'(pk[3]);
  assign push_rec.last = c_flags_r.lc && c_flags_r.lr;

  `LMC_ASSERT(a_accept_enters_b, clk, rst_n, accept |=> b_valid_r, "accepted transfer lost")
  `LMC_ASSERT(a_col_in_range, clk, rst_n, c_pos_r < MAX_COLS, "column position out of range")
endmodule

### design/lmc_fifo.sv
`timescale 1ns / 1ps
`include "local_maximum_counter_core_assert.svh"
module lmc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lmc_pkg::peak_rec_t  push_rec,
  input  logic                pop,
  output lmc_pkg::peak_rec_t  head,
  output lmc_pkg::fifo_stat_t stat
);
  import lmc_pkg::*;

  peak_rec_t          ent_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r;
  logic [FIFO_PW-1:0] rd_ptr_r;
  logic [FIFO_PW:0]   cnt_r;

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (FIFO_PW + 1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_PW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_PW + 1)'(1);
      end
    end
  end

  `LMC_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && stat.full, "push into full queue")
  `LMC_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty, "pop from empty queue")
endmodule

### design/lmc_back.sv
`timescale 1ns / 1ps
`include "local_maximum_counter_core_assert.svh"
module lmc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lmc_pkg::fifo_stat_t         fifo_stat,
  input  lmc_pkg::peak_rec_t          head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lmc_pkg::COUNT_W-1:0] out_peak_count
);
  import lmc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W:0]   sum;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_peak_count_r;

  // a frame end can only drain once the output slot is free
  assign pop = !fifo_stat.empty && (!head.last || !out_valid_r || out_ready);

  assign sum = (COUNT_W + 1)'(count_r) + (COUNT_W + 1)'(head.inc);
  assign count_nxt = (sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        count_r <= head.last ? '0 : count_nxt;
      end
      if (pop && head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_peak_count_r <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_count = out_peak_count_r;

  `LMC_ASSERT(a_count_cleared, clk, rst_n, pop && head.last |=> count_r == '0, "count not cleared")
endmodule

### design/local_maximum_counter_core.sv
`timescale 1ns / 1ps
// Local maximum counter over 3x3 neighborhoods of a streamed frame.
// Input channel (in_valid/in_ready/in_sample): signed samples in raster order,
// frame_rows by frame_cols via the cfg_ APB port (rows at 0x0, columns at 0x4,
// 11 bits each, zero is taken as 1, values above the maximum are clamped). The
// user must change configuration only while no transfer is in flight; unchecked.
// Result channel (out_valid/out_ready/out_peak_count): one transfer per frame,
// the count of strict local maxima, saturating at 2^21-1.
// Throughput: one sample per clock while in_ready is high, bounded by the
// line store, which is read and written once per cycle. After a frame's last
// sample, its result passes stages B and C, the queue and the output register.
// A small queue sits between the window/compare pipeline and the counter, and
// the result sits in an output register, so the input keeps flowing while a
// result waits; only when the receiver stalls long enough for the queue to
// fill does in_ready drop.
// Reset (synchronous, rst_n low) clears positions, window, count and queue
// and sets both dimensions to 1024; the line stores need no clearing pass.
module local_maximum_counter_core #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lmc_pkg::COUNT_W-1:0]    out_peak_count,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lmc_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [lmc_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [lmc_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import lmc_pkg::*;

  logic [CFG_W-1:0] frame_rows_r;
  logic [CFG_W-1:0] frame_cols_r;
  logic             cfg_wr;
  reg_idx_t         cfg_sel;

  fifo_stat_t fifo_stat;
  peak_rec_t  push_rec;
  peak_rec_t  head;
  logic       push;
  logic       pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= DIM_RESET;
      frame_cols_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_ROWS: frame_rows_r <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_COLS: frame_cols_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_ROWS: cfg_prdata = APB_DW'(frame_rows_r);
      REG_FRAME_COLS: cfg_prdata = APB_DW'(frame_cols_r);
      default:        cfg_prdata = '0;
    endcase
  end

  lmc_front #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .frame_rows (frame_rows_r),
    .frame_cols (frame_cols_r),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_rec   (push_rec)
  );

  lmc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  lmc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_stat      (fifo_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_peak_count (out_peak_count)
  );
endmodule
